// File: rtl/core/nhes_pkg.sv
// ----------------------------------------------------------------------------
// nhes_pkg
// shared types, constants and index tables of the neo-hookean energy unit
// ----------------------------------------------------------------------------
package nhes_pkg;

   // ln 2 in unsigned q0.32
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // reset values of the lame parameters (1.0 in q16.16)
   localparam logic [31:0] MU_RESET     = 32'h0001_0000;
   localparam logic [31:0] LAMBDA_RESET = 32'h0001_0000;

   // register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_SHEAR_MODULUS = 2'd0,
      CSR_LAME_LAMBDA   = 2'd1
   } csr_index_type;

   // cofactor c_i = f[a]*f[b] - f[c]*f[d], row-major indexes
   localparam int CF_A [9] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
   localparam int CF_B [9] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
   localparam int CF_C [9] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
   localparam int CF_D [9] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

   typedef struct packed {
      logic signed [31:0] f_00;
      logic signed [31:0] f_01;
      logic signed [31:0] f_02;
      logic signed [31:0] f_10;
      logic signed [31:0] f_11;
      logic signed [31:0] f_12;
      logic signed [31:0] f_20;
      logic signed [31:0] f_21;
      logic signed [31:0] f_22;
   } req_type;

   typedef struct packed {
      logic signed [63:0] energy_density;
      logic signed [63:0] stress_00;
      logic signed [63:0] stress_01;
      logic signed [63:0] stress_02;
      logic signed [63:0] stress_10;
      logic signed [63:0] stress_11;
      logic signed [63:0] stress_12;
      logic signed [63:0] stress_20;
      logic signed [63:0] stress_21;
      logic signed [63:0] stress_22;
      logic               inverted;
   } rsp_type;

   typedef logic [8:0][31:0] f_array_type;
   typedef logic [8:0][64:0] cof_array_type;

   // one classified item as it travels from front to back
   typedef struct packed {
      f_array_type   f;
      cof_array_type cof;
      logic [96:0]   det;
      logic [66:0]   ssq;
      logic          inv;
   } fe_type;

   // queue status towards the top level
   typedef struct packed {
      logic push;
      logic full;
   } qs_type;

endpackage

// File: rtl/core/neo_hookean_energy_stress_unit.sv
// ----------------------------------------------------------------------------
// neo_hookean_energy_stress_unit
// neo-hookean energy density and first piola stress of one 3x3 gradient
// ----------------------------------------------------------------------------
// a new item (deformation gradient f, signed q16.16) can be started on every
// clock cycle while busy is low; busy is a registered copy of reset. each item
// gives exactly one result, in order, after 4 front stages (products, minors,
// determinant), one queue slot, then the back end whose length is set by 32
// squaring stages of the log2 search and 64 stages of the restoring divider
// that forms the stress quotients. the result is shown for one cycle with
// rsp_strobe and cannot be held off, so the receiver must take it then. energy
// and stress are signed q32.32 and clip at the 64-bit limits; a determinant of
// zero or below gives inverted with all other fields zero. the user must write
// mu and lambda through the csr port only while no item is in flight; the
// block itself does not enforce this. an unknown index is ignored.
// ----------------------------------------------------------------------------
module neo_hookean_energy_stress_unit import nhes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   // lame parameters
   logic [31:0] mu_ff, mu_in;
   logic [31:0] la_ff, la_in;
   logic        busy_ff;

   // front to queue, queue to back
   logic   fe_valid;
   fe_type fe_data;
   logic   bk_valid;
   fe_type bk_data;
   qs_type q_status;

   always_comb begin
      mu_in = mu_ff;
      la_in = la_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_SHEAR_MODULUS: mu_in = csr_wdata;
            CSR_LAME_LAMBDA:   la_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff   <= MU_RESET;
         la_ff   <= LAMBDA_RESET;
         busy_ff <= 1'b1;
      end else begin
         mu_ff   <= mu_in;
         la_ff   <= la_in;
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   // classify: cofactors, determinant, inverted flag
   nhes_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy_ff),
      .in_data   (req_data),
      .out_valid (fe_valid),
      .out_data  (fe_data)
   );

   // decoupling queue, drained every cycle by the back end
   nhes_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_valid),
      .push_data (fe_data),
      .pop_valid (bk_valid),
      .pop_data  (bk_data),
      .status    (q_status)
   );

   // log, energy, divider and output saturation
   nhes_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (bk_valid),
      .in_data   (bk_data),
      .mu        (mu_ff),
      .la        (la_ff),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // an inverted element must come out with zeroed energy and stress
   a_inverted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.inverted |->
         rsp_data.energy_density == '0 && rsp_data.stress_00 == '0 &&
         rsp_data.stress_22 == '0)
      else $error("inverted item with non-zero outputs");

   // the queue is always drained, so it never sees a push while full
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_status.push && q_status.full))
      else $error("queue overflow");

   // nothing leaves the unit straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");
`endif

endmodule

// File: rtl/core/nhes_front.sv
// ----------------------------------------------------------------------------
// nhes_front
// cofactors, sum of squares, determinant and inverted classification
// ----------------------------------------------------------------------------
module nhes_front import nhes_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_data,
   output logic    out_valid,
   output fe_type  out_data
);

   f_array_type      fa;
   f_array_type      f1_ff;
   logic [8:0][63:0] pab1_in, pab1_ff;
   logic [8:0][63:0] pcd1_in, pcd1_ff;
   logic [8:0][63:0] sqr1_in, sqr1_ff;
   logic             v1_ff;

   f_array_type      f2_ff;
   cof_array_type    cof2_in, cof2_ff;
   logic [66:0]      ssq2_in, ssq2_ff;
   logic             v2_ff;

   f_array_type      f3_ff;
   cof_array_type    cof3_ff;
   logic [66:0]      ssq3_ff;
   logic [2:0][64:0] plo3_in, plo3_ff;
   logic [2:0][64:0] phi3_in, phi3_ff;
   logic             v3_ff;

   logic signed [96:0] det4_in;
   fe_type             o4_ff;
   logic               v4_ff;

   always_comb begin
      fa[0] = in_data.f_00;
      fa[1] = in_data.f_01;
      fa[2] = in_data.f_02;
      fa[3] = in_data.f_10;
      fa[4] = in_data.f_11;
      fa[5] = in_data.f_12;
      fa[6] = in_data.f_20;
      fa[7] = in_data.f_21;
      fa[8] = in_data.f_22;
      for (int i = 0; i < 9; i++) begin
         pab1_in[i] = $signed(fa[CF_A[i]]) * $signed(fa[CF_B[i]]);
         pcd1_in[i] = $signed(fa[CF_C[i]]) * $signed(fa[CF_D[i]]);
         sqr1_in[i] = $signed(fa[i]) * $signed(fa[i]);
      end
   end

   // minors and sum of squares
   always_comb begin
      ssq2_in = '0;
      for (int i = 0; i < 9; i++) begin
         cof2_in[i] = $signed(pab1_ff[i]) - $signed(pcd1_ff[i]);
         ssq2_in    = ssq2_in + 67'(sqr1_ff[i]);
      end
   end

   // first row times its cofactors, split at bit 32
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         plo3_in[i] = $signed(f2_ff[i]) * $signed({1'b0, cof2_ff[i][31:0]});
         phi3_in[i] = $signed(f2_ff[i]) * $signed(cof2_ff[i][64:32]);
      end
   end

   always_comb begin
      det4_in = '0;
      for (int i = 0; i < 3; i++) begin
         det4_in = det4_in + (97'($signed(phi3_ff[i])) <<< 32) + 97'($signed(plo3_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      f1_ff   <= fa;
      pab1_ff <= pab1_in;
      pcd1_ff <= pcd1_in;
      sqr1_ff <= sqr1_in;
      f2_ff   <= f1_ff;
      cof2_ff <= cof2_in;
      ssq2_ff <= ssq2_in;
      f3_ff   <= f2_ff;
      cof3_ff <= cof2_ff;
      ssq3_ff <= ssq2_ff;
      plo3_ff <= plo3_in;
      phi3_ff <= phi3_in;
      o4_ff.f   <= f3_ff;
      o4_ff.cof <= cof3_ff;
      o4_ff.ssq <= ssq3_ff;
      o4_ff.det <= det4_in;
      o4_ff.inv <= det4_in[96] || (det4_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = o4_ff;

endmodule

// File: rtl/core/nhes_queue.sv
// ----------------------------------------------------------------------------
// nhes_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module nhes_queue import nhes_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  fe_type push_data,
   output logic   pop_valid,
   output fe_type pop_data,
   output qs_type status
);

   fe_type     mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   // the back end never stalls, so whatever is queued is taken
   assign pop = (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign pop_valid   = pop;
   assign pop_data    = mem_ff[rd_ptr_ff];
   assign status.push = push;
   assign status.full = (count_ff == 2'd2);

endmodule

// File: rtl/core/nhes_back.sv
// ----------------------------------------------------------------------------
// nhes_back
// log of the determinant, energy, stress quotients and saturation
// ----------------------------------------------------------------------------
module nhes_back import nhes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  fe_type      in_data,
   input  logic [31:0] mu,
   input  logic [31:0] la,
   output logic        out_valid,
   output rsp_type     out_data
);

   typedef struct packed {
      fe_type      ctx;
      logic [6:0]  p;
      logic [31:0] m;
      logic [31:0] frac;
   } lc_type;

   typedef struct packed {
      f_array_type f;
      logic [95:0] den;
      logic        inv;
      logic [63:0] energy;
      logic [8:0]  neg;
      logic [8:0]  over;
   } sd_type;

   typedef struct packed {
      logic [136:0] rem;
      logic [63:0]  q;
   } dv_type;

   function automatic logic [63:0] sat64(input logic signed [127:0] x);
      if (x > $signed({64'd0, 64'h7FFF_FFFF_FFFF_FFFF})) begin
         return 64'h7FFF_FFFF_FFFF_FFFF;
      end else if (x < $signed({{64{1'b1}}, 64'h8000_0000_0000_0000})) begin
         return 64'h8000_0000_0000_0000;
      end else begin
         return x[63:0];
      end
   endfunction

   // ---------------- entry and leading-one search
   fe_type          b0_ff;
   logic            b0v_ff;
   fe_type          l1_ctx_ff;
   logic [3:0]      l1_nz_in, l1_nz_ff;
   logic [3:0][4:0] l1_idx_in, l1_idx_ff;
   logic            l1v_ff;
   fe_type          l2_ctx_ff;
   logic [6:0]      l2_p_in, l2_p_ff;
   logic            l2v_ff;
   lc_type          lc_in [33];
   lc_type          lc_ff [33];
   logic            lcv_ff [33];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         l1_nz_in[c]  = |b0_ff.det[c*24 +: 24];
         l1_idx_in[c] = '0;
         for (int b = 0; b < 24; b++) begin
            if (b0_ff.det[c*24 + b]) l1_idx_in[c] = 5'(b);
         end
      end
   end

   always_comb begin
      l2_p_in = '0;
      for (int c = 0; c < 4; c++) begin
         if (l1_nz_ff[c]) l2_p_in = 7'(c * 24) + {2'b0, l1_idx_ff[c]};
      end
   end

   // normalise to q1.31
   always_comb begin
      lc_in[0].ctx  = l2_ctx_ff;
      lc_in[0].p    = l2_p_ff;
      lc_in[0].frac = '0;
      if (l2_p_ff >= 7'd31) begin
         lc_in[0].m = 32'(l2_ctx_ff.det[95:0] >> (l2_p_ff - 7'd31));
      end else begin
         lc_in[0].m = 32'(l2_ctx_ff.det[95:0] << (7'd31 - l2_p_ff));
      end
   end

   // one fraction bit per squaring stage
   for (genvar j = 1; j < 33; j++) begin : g_sq
      localparam int BIT = 32 - j;
      logic [63:0] mm;
      always_comb begin
         mm          = lc_ff[j-1].m * lc_ff[j-1].m;
         lc_in[j]    = lc_ff[j-1];
         if (mm[63]) begin
            lc_in[j].m         = mm[63:32];
            lc_in[j].frac[BIT] = 1'b1;
         end else begin
            lc_in[j].m = mm[62:31];
         end
      end
   end

   always_ff @(posedge clock) begin
      b0_ff     <= in_data;
      l1_ctx_ff <= b0_ff;
      l1_nz_ff  <= l1_nz_in;
      l1_idx_ff <= l1_idx_in;
      l2_ctx_ff <= l1_ctx_ff;
      l2_p_ff   <= l2_p_in;
      for (int j = 0; j < 33; j++) lc_ff[j] <= lc_in[j];
   end

   // ---------------- log j
   fe_type             fr_ctx_ff;
   logic [63:0]        fr_fl_in, fr_fl_ff;
   logic signed [40:0] fr_pl_in, fr_pl_ff;
   logic               frv_ff;
   fe_type             lg_ctx_ff;
   logic [64:0]        lg_sum;
   logic [39:0]        lg_in, lg_ff;
   logic               lgv_ff;

   always_comb begin
      fr_fl_in = lc_ff[32].frac * LN2_Q32;
      fr_pl_in = ($signed({1'b0, lc_ff[32].p}) - 8'sd48) * $signed({1'b0, LN2_Q32});
      lg_sum   = {1'b0, fr_fl_ff} + 65'h0_8000_0000;
      lg_in    = 40'(fr_pl_ff) + {7'd0, lg_sum[64:32]};
   end

   always_ff @(posedge clock) begin
      fr_ctx_ff <= lc_ff[32].ctx;
      fr_fl_ff  <= fr_fl_in;
      fr_pl_ff  <= fr_pl_in;
      lg_ctx_ff <= fr_ctx_ff;
      lg_ff     <= lg_in;
   end

   // ---------------- energy and stress coefficient
   fe_type             e1_ctx_ff;
   logic [38:0]        alg;
   logic signed [34:0] dhi;
   logic [39:0]        e1_qll_in, e1_qll_ff;
   logic [38:0]        e1_qlh_in, e1_qlh_ff;
   logic [37:0]        e1_qhh_in, e1_qhh_ff;
   logic [51:0]        e1_ml_in, e1_ml_ff, e1_ll_in, e1_ll_ff;
   logic signed [52:0] e1_mh_in, e1_mh_ff, e1_lh_in, e1_lh_ff;
   logic [63:0]        e1_dl_in, e1_dl_ff;
   logic signed [67:0] e1_dh_in, e1_dh_ff;
   logic               e1v_ff;

   always_comb begin
      alg       = 39'(lg_ff[39] ? -lg_ff : lg_ff);
      dhi       = $signed(lg_ctx_ff.ssq[66:32]) - 35'sd3;
      e1_qll_in = alg[19:0] * alg[19:0];
      e1_qlh_in = alg[19:0] * alg[38:20];
      e1_qhh_in = alg[38:20] * alg[38:20];
      e1_ml_in  = mu * lg_ff[19:0];
      e1_mh_in  = $signed({1'b0, mu}) * $signed(lg_ff[39:20]);
      e1_ll_in  = la * lg_ff[19:0];
      e1_lh_in  = $signed({1'b0, la}) * $signed(lg_ff[39:20]);
      e1_dl_in  = mu * lg_ctx_ff.ssq[31:0];
      e1_dh_in  = $signed({1'b0, mu}) * dhi;
   end

   fe_type       e2_ctx_ff;
   logic [77:0]  lgsq;
   logic [45:0]  e2_sq_in, e2_sq_ff;
   logic [73:0]  e2_mulg_in, e2_mulg_ff, e2_lalg_in, e2_lalg_ff;
   logic [100:0] e2_mud_in, e2_mud_ff;
   logic         e2v_ff;

   always_comb begin
      lgsq       = (78'(e1_qhh_ff) << 40) + (78'(e1_qlh_ff) << 21) + 78'(e1_qll_ff);
      e2_sq_in   = lgsq[77:32];
      e2_mulg_in = (74'(e1_mh_ff) << 20) + 74'(e1_ml_ff);
      e2_lalg_in = (74'(e1_lh_ff) << 20) + 74'(e1_ll_ff);
      e2_mud_in  = (101'(e1_dh_ff) << 32) + 101'(e1_dl_ff);
   end

   fe_type       e3_ctx_ff;
   logic [63:0]  e3_psl_in, e3_psl_ff;
   logic [45:0]  e3_psh_in, e3_psh_ff;
   logic [57:0]  e3_coef_in, e3_coef_ff;
   logic [73:0]  e3_mulg_ff;
   logic [100:0] e3_mud_ff;
   logic         e3v_ff;

   always_comb begin
      e3_psl_in  = la * e2_sq_ff[31:0];
      e3_psh_in  = la * e2_sq_ff[45:32];
      e3_coef_in = 58'($signed(e2_lalg_ff) >>> 16) - 58'({mu, 16'd0});
   end

   fe_type              e4_ctx_ff;
   logic signed [100:0] e4_two_e_in, e4_two_e_ff;
   logic [56:0]         e4_acoef_in, e4_acoef_ff;
   logic                e4_cneg_ff;
   logic                e4v_ff;

   always_comb begin
      e4_two_e_in = e3_mud_ff - (101'($signed(e3_mulg_ff)) << 1)
                  + (101'(e3_psh_ff) << 32) + 101'(e3_psl_ff);
      e4_acoef_in = 57'(e3_coef_ff[57] ? -e3_coef_ff : e3_coef_ff);
   end

   sd_type           e5_sd_in, e5_sd_ff;
   logic [8:0][63:0] e5_acof_in, e5_acof_ff;
   logic [56:0]      e5_acoef_ff;
   logic             e5v_ff;

   always_comb begin
      e5_sd_in.f      = e4_ctx_ff.f;
      e5_sd_in.den    = e4_ctx_ff.det[95:0];
      e5_sd_in.inv    = e4_ctx_ff.inv;
      e5_sd_in.energy = sat64(128'(e4_two_e_ff >>> 17));
      e5_sd_in.over   = '0;
      for (int i = 0; i < 9; i++) begin
         e5_acof_in[i]   = 64'(e4_ctx_ff.cof[i][64] ? -e4_ctx_ff.cof[i] : e4_ctx_ff.cof[i]);
         e5_sd_in.neg[i] = e4_ctx_ff.cof[i][64] ^ e4_cneg_ff;
      end
   end

   // magnitude of coef * cofactor as four partial products
   sd_type           e6_sd_ff;
   logic [8:0][63:0] e6_ll_in, e6_ll_ff, e6_lh_in, e6_lh_ff;
   logic [8:0][56:0] e6_hl_in, e6_hl_ff, e6_hh_in, e6_hh_ff;
   logic             e6v_ff;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         e6_ll_in[i] = e5_acoef_ff[31:0] * e5_acof_ff[i][31:0];
         e6_lh_in[i] = e5_acoef_ff[31:0] * e5_acof_ff[i][63:32];
         e6_hl_in[i] = e5_acoef_ff[56:32] * e5_acof_ff[i][31:0];
         e6_hh_in[i] = e5_acoef_ff[56:32] * e5_acof_ff[i][63:32];
      end
   end

   sd_type            e7_sd_ff;
   logic [8:0][120:0] e7_nmag_in, e7_nmag_ff;
   logic              e7v_ff;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         e7_nmag_in[i] = (121'(e6_hh_ff[i]) << 64)
                       + ((121'(e6_lh_ff[i]) + 121'(e6_hl_ff[i])) << 32)
                       + 121'(e6_ll_ff[i]);
      end
   end

   // ---------------- restoring division, one quotient bit per stage
   sd_type sd_in [65];
   sd_type sd_ff [65];
   dv_type dv_in [65][9];
   dv_type dv_ff [65][9];
   logic   dvv_ff [65];

   always_comb begin
      sd_in[0] = e7_sd_ff;
      for (int i = 0; i < 9; i++) begin
         dv_in[0][i].rem   = {e7_nmag_ff[i], 16'd0};
         dv_in[0][i].q     = '0;
         sd_in[0].over[i]  = (160'({e7_nmag_ff[i], 16'd0}) >= {e7_sd_ff.den, 64'd0});
      end
   end

   for (genvar j = 1; j < 65; j++) begin : g_div
      localparam int K = 64 - j;
      logic [159:0] shifted;
      always_comb begin
         sd_in[j] = sd_ff[j-1];
         shifted  = 160'(sd_ff[j-1].den) << K;
         for (int i = 0; i < 9; i++) begin
            dv_in[j][i] = dv_ff[j-1][i];
            if (160'(dv_ff[j-1][i].rem) >= shifted) begin
               dv_in[j][i].rem  = dv_ff[j-1][i].rem - shifted[136:0];
               dv_in[j][i].q[K] = 1'b1;
            end
         end
      end
   end

   // ---------------- sign, mu*f and saturation
   logic [8:0][64:0] p1_t_in, p1_t_ff, p1_muf_in, p1_muf_ff;
   logic [63:0]      p1_energy_ff;
   logic             p1_inv_ff;
   logic             p1v_ff;
   logic [63:0]      qf;
   rsp_type          p2_in, p2_ff;
   logic             p2v_ff;
   logic [8:0][63:0] st;

   always_comb begin
      qf = '0;
      for (int i = 0; i < 9; i++) begin
         qf           = sd_ff[64].over[i] ? '1 : dv_ff[64][i].q;
         p1_t_in[i]   = sd_ff[64].neg[i] ? -{1'b0, qf} : {1'b0, qf};
         p1_muf_in[i] = $signed({1'b0, mu}) * $signed(sd_ff[64].f[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         st[i] = sat64(128'($signed(p1_t_ff[i])) + 128'($signed(p1_muf_ff[i])));
      end
      if (p1_inv_ff) begin
         p2_in          = '0;
         p2_in.inverted = 1'b1;
      end else begin
         p2_in.energy_density = p1_energy_ff;
         p2_in.stress_00      = st[0];
         p2_in.stress_01      = st[1];
         p2_in.stress_02      = st[2];
         p2_in.stress_10      = st[3];
         p2_in.stress_11      = st[4];
         p2_in.stress_12      = st[5];
         p2_in.stress_20      = st[6];
         p2_in.stress_21      = st[7];
         p2_in.stress_22      = st[8];
         p2_in.inverted       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      e1_ctx_ff   <= lg_ctx_ff;
      e1_qll_ff   <= e1_qll_in;
      e1_qlh_ff   <= e1_qlh_in;
      e1_qhh_ff   <= e1_qhh_in;
      e1_ml_ff    <= e1_ml_in;
      e1_mh_ff    <= e1_mh_in;
      e1_ll_ff    <= e1_ll_in;
      e1_lh_ff    <= e1_lh_in;
      e1_dl_ff    <= e1_dl_in;
      e1_dh_ff    <= e1_dh_in;
      e2_ctx_ff   <= e1_ctx_ff;
      e2_sq_ff    <= e2_sq_in;
      e2_mulg_ff  <= e2_mulg_in;
      e2_lalg_ff  <= e2_lalg_in;
      e2_mud_ff   <= e2_mud_in;
      e3_ctx_ff   <= e2_ctx_ff;
      e3_psl_ff   <= e3_psl_in;
      e3_psh_ff   <= e3_psh_in;
      e3_coef_ff  <= e3_coef_in;
      e3_mulg_ff  <= e2_mulg_ff;
      e3_mud_ff   <= e2_mud_ff;
      e4_ctx_ff   <= e3_ctx_ff;
      e4_two_e_ff <= e4_two_e_in;
      e4_acoef_ff <= e4_acoef_in;
      e4_cneg_ff  <= e3_coef_ff[57];
      e5_sd_ff    <= e5_sd_in;
      e5_acof_ff  <= e5_acof_in;
      e5_acoef_ff <= e4_acoef_ff;
      e6_sd_ff    <= e5_sd_ff;
      e6_ll_ff    <= e6_ll_in;
      e6_lh_ff    <= e6_lh_in;
      e6_hl_ff    <= e6_hl_in;
      e6_hh_ff    <= e6_hh_in;
      e7_sd_ff    <= e6_sd_ff;
      e7_nmag_ff  <= e7_nmag_in;
      for (int j = 0; j < 65; j++) begin
         sd_ff[j] <= sd_in[j];
         for (int i = 0; i < 9; i++) dv_ff[j][i] <= dv_in[j][i];
      end
      p1_t_ff      <= p1_t_in;
      p1_muf_ff    <= p1_muf_in;
      p1_energy_ff <= sd_ff[64].energy;
      p1_inv_ff    <= sd_ff[64].inv;
      p2_ff        <= p2_in;
   end

   // valid bits alongside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         b0v_ff <= 1'b0;
         l1v_ff <= 1'b0;
         l2v_ff <= 1'b0;
         for (int j = 0; j < 33; j++) lcv_ff[j] <= 1'b0;
         frv_ff <= 1'b0;
         lgv_ff <= 1'b0;
         e1v_ff <= 1'b0;
         e2v_ff <= 1'b0;
         e3v_ff <= 1'b0;
         e4v_ff <= 1'b0;
         e5v_ff <= 1'b0;
         e6v_ff <= 1'b0;
         e7v_ff <= 1'b0;
         for (int j = 0; j < 65; j++) dvv_ff[j] <= 1'b0;
         p1v_ff <= 1'b0;
         p2v_ff <= 1'b0;
      end else begin
         b0v_ff    <= in_valid;
         l1v_ff    <= b0v_ff;
         l2v_ff    <= l1v_ff;
         lcv_ff[0] <= l2v_ff;
         for (int j = 1; j < 33; j++) lcv_ff[j] <= lcv_ff[j-1];
         frv_ff    <= lcv_ff[32];
         lgv_ff    <= frv_ff;
         e1v_ff    <= lgv_ff;
         e2v_ff    <= e1v_ff;
         e3v_ff    <= e2v_ff;
         e4v_ff    <= e3v_ff;
         e5v_ff    <= e4v_ff;
         e6v_ff    <= e5v_ff;
         e7v_ff    <= e6v_ff;
         dvv_ff[0] <= e7v_ff;
         for (int j = 1; j < 65; j++) dvv_ff[j] <= dvv_ff[j-1];
         p1v_ff    <= dvv_ff[64];
         p2v_ff    <= p1v_ff;
      end
   end

   assign out_valid = p2v_ff;
   assign out_data  = p2_ff;

endmodule

// File: tb/neo_hookean_energy_stress_unit_checker.sv
// ----------------------------------------------------------------------------
// neo_hookean_energy_stress_unit_checker
// watches both channels, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module neo_hookean_energy_stress_unit_checker import nhes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_strobe,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [127:0] I64_MAX = {64'h0, 64'h7FFF_FFFF_FFFF_FFFF};
   localparam logic signed [127:0] I64_MIN = {{64{1'b1}}, 64'h8000_0000_0000_0000};

   logic [31:0] mu_reg;
   logic [31:0] lambda_reg;
   rsp_type     expected_rsps[$];

   function automatic logic signed [63:0] clip64(logic signed [127:0] a);
      if (a > I64_MAX) return I64_MAX[63:0];
      if (a < I64_MIN) return I64_MIN[63:0];
      return a[63:0];
   endfunction

   // natural log of a positive q48.48 determinant, q32.32
   function automatic longint ln_q48(logic [127:0] j);
      int          p;
      logic [63:0] m;
      logic [63:0] frac;
      logic [64:0] tail;
      longint      lead;
      p = 127;
      while (p > 0 && !j[p]) p--;
      if (p >= 31) m = 64'(j >> (p - 31));
      else m = 64'(j << (31 - p));
      frac = '0;
      for (int i = 31; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac[i] = 1'b1;
         end
      end
      tail = 65'(frac) * 65'(LN2_Q32) + 65'h8000_0000;
      lead = longint'(p - 48) * longint'(LN2_Q32);
      return lead + longint'(tail >> 32);
   endfunction

   function automatic rsp_type predict_energy_stress(req_type r, logic [31:0] mu,
                                                     logic [31:0] la);
      logic signed [127:0] f[9];
      logic signed [127:0] cof[9];
      logic signed [127:0] det, ssq, two_e, coef, mu_w, la_w, lg_w, sq, n, t;
      logic        [127:0] mag;
      logic        [159:0] quo;
      logic        [63:0]  st[9];
      rsp_type             o;
      o = '0;
      f[0] = r.f_00; f[1] = r.f_01; f[2] = r.f_02;
      f[3] = r.f_10; f[4] = r.f_11; f[5] = r.f_12;
      f[6] = r.f_20; f[7] = r.f_21; f[8] = r.f_22;
      cof[0] = f[4] * f[8] - f[5] * f[7];
      cof[1] = f[5] * f[6] - f[3] * f[8];
      cof[2] = f[3] * f[7] - f[4] * f[6];
      cof[3] = f[2] * f[7] - f[1] * f[8];
      cof[4] = f[0] * f[8] - f[2] * f[6];
      cof[5] = f[1] * f[6] - f[0] * f[7];
      cof[6] = f[1] * f[5] - f[2] * f[4];
      cof[7] = f[2] * f[3] - f[0] * f[5];
      cof[8] = f[0] * f[4] - f[1] * f[3];
      det = f[0] * cof[0] + f[1] * cof[1] + f[2] * cof[2];
      if (det <= 0) begin
         o.inverted = 1'b1;
         return o;
      end
      mu_w = $signed({96'h0, mu});
      la_w = $signed({96'h0, la});
      lg_w = $signed({{64{1'b0}}, 64'h0}) + longint'(ln_q48(det));
      ssq = '0;
      for (int i = 0; i < 9; i++) ssq = ssq + f[i] * f[i];
      sq = (lg_w * lg_w) >>> 32;
      two_e = mu_w * (ssq - 128'sd12884901888) - 2 * (mu_w * lg_w) + la_w * sq;
      o.energy_density = clip64(two_e >>> 17);
      coef = ((la_w * lg_w) >>> 16) - (mu_w <<< 16);
      for (int i = 0; i < 9; i++) begin
         n   = coef * cof[i];
         mag = (n < 0) ? -n : n;
         quo = {mag, 16'h0} / {32'h0, det};
         t   = (quo[159:64] != '0) ? {64'h0, {64{1'b1}}} : {64'h0, quo[63:0]};
         if (n < 0) t = -t;
         t = t + mu_w * f[i];
         st[i] = clip64(t);
      end
      o.stress_00 = st[0]; o.stress_01 = st[1]; o.stress_02 = st[2];
      o.stress_10 = st[3]; o.stress_11 = st[4]; o.stress_12 = st[5];
      o.stress_20 = st[6]; o.stress_21 = st[7]; o.stress_22 = st[8];
      return o;
   endfunction

   task automatic compare_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         $error("%s: expected %h, got %h", name, e, a);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         mu_reg     <= MU_RESET;
         lambda_reg <= LAMBDA_RESET;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $error("result with no item outstanding");
               fail_count++;
            end else begin
               e = expected_rsps.pop_front();
               compare_field("energy_density", e.energy_density, rsp_data.energy_density);
               compare_field("stress_00", e.stress_00, rsp_data.stress_00);
               compare_field("stress_01", e.stress_01, rsp_data.stress_01);
               compare_field("stress_02", e.stress_02, rsp_data.stress_02);
               compare_field("stress_10", e.stress_10, rsp_data.stress_10);
               compare_field("stress_11", e.stress_11, rsp_data.stress_11);
               compare_field("stress_12", e.stress_12, rsp_data.stress_12);
               compare_field("stress_20", e.stress_20, rsp_data.stress_20);
               compare_field("stress_21", e.stress_21, rsp_data.stress_21);
               compare_field("stress_22", e.stress_22, rsp_data.stress_22);
               compare_field("inverted", 64'(e.inverted), 64'(rsp_data.inverted));
            end
         end
         if (start && !busy)
            expected_rsps.push_back(predict_energy_stress(req_data, mu_reg, lambda_reg));
         if (csr_we) begin
            if (csr_addr == CSR_SHEAR_MODULUS) mu_reg <= csr_wdata;
            else if (csr_addr == CSR_LAME_LAMBDA) lambda_reg <= csr_wdata;
         end
      end
      pending = expected_rsps.size();
   end

endmodule

// File: tb/neo_hookean_energy_stress_unit_test.sv
// ----------------------------------------------------------------------------
// neo_hookean_energy_stress_unit_test
// directed and random deformation gradients under several lame settings
// ----------------------------------------------------------------------------
// the top drives items and register writes; the checker beside the block
// predicts every result and counts mismatches. random items are mostly
// well-formed gradients near identity, with noise, tiny, inverted and fully
// random matrices mixed in.
// ----------------------------------------------------------------------------
module neo_hookean_energy_stress_unit_test import nhes_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // an index with no register behind it
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam int PIPE_LATENCY = 117;
   localparam int IDLE_LIMIT   = 4000;
   localparam int ITEMS_PER_PHASE = 360;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [31:0] csr_wdata;
   int          fail_count;
   int          pending;
   int          idle_cycles;
   bit          burst_mode;

   neo_hookean_energy_stress_unit u_top (
      .clock, .reset, .start, .busy, .req_data,
      .rsp_strobe, .rsp_data, .csr_we, .csr_addr, .csr_wdata
   );

   neo_hookean_energy_stress_unit_checker u_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .csr_we, .csr_addr, .csr_wdata, .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: cycles in which neither side moves anything
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** neo_hookean_energy_stress_unit: FAILED **");
         $finish;
      end
   end

   // one item, after a random gap unless in a burst stretch
   task automatic send_item(req_type r);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // stop sending and let every outstanding item come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_lame(logic [31:0] mu, logic [31:0] la);
      drain();
      write_reg(CSR_SHEAR_MODULUS, mu);
      write_reg(CSR_LAME_LAMBDA, la);
   endtask

   function automatic req_type diag_matrix(logic signed [31:0] a, logic signed [31:0] b,
                                           logic signed [31:0] c);
      req_type r;
      r = '0;
      r.f_00 = a;
      r.f_11 = b;
      r.f_22 = c;
      return r;
   endfunction

   // random gradient, shape chosen by weight
   function automatic req_type random_gradient();
      req_type r;
      int      kind;
      int      spread;
      logic signed [31:0] tmp;
      kind = $urandom_range(0, 99);
      r = '0;
      if (kind < 60) begin
         // near identity, the well-formed case
         spread = ($urandom_range(0, 3) == 0) ? 65536 : 16384;
         r = diag_matrix(32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
         r.f_00 += $signed($urandom_range(0, 2 * spread)) - spread;
         r.f_01  = $signed($urandom_range(0, 2 * spread)) - spread;
         r.f_02  = $signed($urandom_range(0, 2 * spread)) - spread;
         r.f_10  = $signed($urandom_range(0, 2 * spread)) - spread;
         r.f_11 += $signed($urandom_range(0, 2 * spread)) - spread;
         r.f_12  = $signed($urandom_range(0, 2 * spread)) - spread;
         r.f_20  = $signed($urandom_range(0, 2 * spread)) - spread;
         r.f_21  = $signed($urandom_range(0, 2 * spread)) - spread;
         r.f_22 += $signed($urandom_range(0, 2 * spread)) - spread;
      end else if (kind < 75) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom};
      end else if (kind < 85) begin
         // tiny entries, tiny determinant
         r.f_00 = $urandom_range(0, 64);
         r.f_11 = $urandom_range(0, 64);
         r.f_22 = $urandom_range(0, 64);
         r.f_01 = $signed($urandom_range(0, 8)) - 4;
         r.f_12 = $signed($urandom_range(0, 8)) - 4;
      end else if (kind < 95) begin
         // swapped entries, det of either sign or zero
         r = diag_matrix(32'sh1_0000 + $signed($urandom_range(0, 8192)),
                         32'sh1_0000, -32'sh1_0000);
         r.f_01 = $signed($urandom_range(0, 8192)) - 4096;
         tmp = r.f_00; r.f_00 = r.f_10; r.f_10 = tmp;
         r.f_22 = -$signed($urandom_range(1, 131072));
      end else begin
         // large stretch
         r = diag_matrix($urandom, $urandom_range(1, 32'h7FFF_FFFF),
                         $urandom_range(1, 32'h7FFF_FFFF));
      end
      return r;
   endfunction

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         // occasional stretches with no gaps
         if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         send_item(random_gradient());
      end
   endtask

   initial begin
      req_type r;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      csr_we     = 1'b0;
      csr_addr   = CSR_SHEAR_MODULUS;
      csr_wdata  = '0;
      burst_mode = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset values
      send_item(diag_matrix(32'sh1_0000, 32'sh1_0000, 32'sh1_0000));   // identity
      send_item('0);                                                   // degenerate
      send_item(diag_matrix(-32'sh1_0000, -32'sh1_0000, -32'sh1_0000)); // inverted
      send_item(diag_matrix(32'sh1, 32'sh1, 32'sh1));                  // tiny det
      send_item(diag_matrix(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      send_item(diag_matrix(32'sh8000_0000, 32'sh8000_0000, -32'sh1_0000));
      send_item({9{32'sh7FFF_FFFF}});                                  // singular
      send_item({9{32'sh8000_0000}});
      send_item(diag_matrix(32'sh64_0000, 32'sh1_0000, 32'sh1_0000));  // stretch 100
      send_item(diag_matrix(32'sh8000, 32'sh2_0000, 32'sh1_0000));
      r = diag_matrix(32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
      r.f_01 = 32'sh8000;
      send_item(r);                                                    // shear
      r = diag_matrix(32'sh0, 32'sh0, 32'sh1_0000);
      r.f_01 = -32'sh1_0000;
      r.f_10 = 32'sh1_0000;
      send_item(r);                                                    // rotation
      send_item(diag_matrix(32'sh1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));

      // extremes of the lame parameters with the same shapes
      set_lame(32'h0, 32'h0);
      write_reg(CSR_UNMAPPED, 32'hDEAD_BEEF);                          // ignored
      send_item(diag_matrix(32'sh1, 32'sh1, 32'sh1));
      send_item(diag_matrix(32'sh2_0000, 32'sh1_0000, 32'sh1_0000));
      set_lame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(diag_matrix(32'sh1, 32'sh1, 32'sh1));
      send_item(diag_matrix(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      send_item(diag_matrix(32'sh1_0000, 32'sh1_0000, 32'sh1_0000));

      // random phases
      run_random(ITEMS_PER_PHASE / 2);
      drain();                                                         // full pause
      run_random(ITEMS_PER_PHASE / 2);
      set_lame(32'h0, 32'hFFFF_FFFF);
      write_reg(CSR_UNMAPPED - 2'd1, 32'h1234_5678);                   // ignored
      run_random(ITEMS_PER_PHASE);
      set_lame(32'h1_0000, 32'h1_0000);
      run_random(ITEMS_PER_PHASE);
      set_lame($urandom, $urandom);
      run_random(ITEMS_PER_PHASE);
      set_lame($urandom_range(0, 32'h10_0000), $urandom_range(0, 32'h10_0000));
      run_random(ITEMS_PER_PHASE);

      // wait out the pipeline
      drain();
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("** neo_hookean_energy_stress_unit: PASSED **");
      end else begin
         if (pending != 0) $error("%0d items never produced a result", pending);
         $display("** neo_hookean_energy_stress_unit: FAILED **");
      end
      $finish;
   end

endmodule
